// ===== src/lobu_pkg.sv =====
// Shared types and constants of the limit order book update block.
package lobu_pkg;

  localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;
  localparam int          ADDR_W    = 3;
  localparam logic        REG_BASE_PRICE = 1'b0;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_EXECUTE = 3'd1;
  localparam logic [2:0] CMD_CANCEL  = 3'd2;
  localparam logic [2:0] CMD_DELETE  = 3'd3;
  localparam logic [2:0] CMD_REPLACE = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_UNKNOWN = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  typedef struct packed {
    logic        used;
    logic        side;
    logic [31:0] shares;
    logic [31:0] price;
    logic [63:0] key;
  } slot_t;

  typedef struct packed {
    logic [31:0] bid_total;
    logic [12:0] bid_count;
    logic [31:0] ask_total;
    logic [12:0] ask_count;
  } level_t;

  typedef enum logic [4:0] {
    S_IDLE, S_FIND_HASH, S_FIND_RD, S_FIND_CK, S_TAKE_RD, S_TAKE_WR,
    S_ER_START, S_ER_RD, S_ER_CK, S_ER_HASH, S_ER_END,
    S_INS_HASH, S_INS_RD, S_INS_CK, S_GIVE_RD, S_GIVE_WR,
    S_SC_START, S_SC_RD, S_SC_CK, S_OUT_RD, S_OUT_WR
  } st_t;

  typedef enum logic [2:0] {
    H_IDLE, H_M0, H_M1, H_M2, H_SUM, H_MOD, H_DONE
  } hst_t;

endpackage

// ===== src/lobu_ram.sv =====
// Single-port-write, registered-read memory with a clearing pass on reset or request.
module lobu_ram import lobu_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clr,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  output logic                     busy
);
  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic             clr_on;
  logic [AW-1:0]    clr_idx;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      clr_on  <= 1'b1;
      clr_idx <= '0;
    end else if (clr_on) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == LAST) clr_on <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_on) begin
      mem[clr_idx] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign busy = clr_on;
endmodule

// ===== src/lobu_hash.sv =====
// Multi-cycle home slot hash: 64-bit multiply from 32x32 partial products, then reduction.
module lobu_hash import lobu_pkg::*; #(
  parameter int SLOTS = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [63:0]              key,
  output logic                     done,
  output logic [$clog2(SLOTS)-1:0] home
);
  localparam int SW = $clog2(SLOTS);
  localparam bit POW2 = (SLOTS == (1 << SW));
  localparam logic [SW:0] SLOT_N = (SW+1)'(SLOTS);

  hst_t        state, state_next;
  logic [63:0] key_r;
  logic [63:0] prod;
  logic [31:0] acc;
  logic [SW-1:0] rem;
  logic [4:0]  cnt;
  logic [31:0] mul_a, mul_b;
  logic [SW:0] sh;

  always_comb begin
    state_next = state;
    unique case (state)
      H_IDLE:  if (start) state_next = H_M0;
      H_M0:    state_next = H_M1;
      H_M1:    state_next = H_M2;
      H_M2:    state_next = H_SUM;
      H_SUM:   state_next = POW2 ? H_DONE : H_MOD;
      H_MOD:   if (cnt == 5'd31) state_next = H_DONE;
      H_DONE:  state_next = H_IDLE;
      default: state_next = H_IDLE;
    endcase
  end

  always_comb begin
    done = (state == H_DONE);
    home = POW2 ? acc[SW-1:0] : rem;
    mul_a = key_r[31:0];
    mul_b = HASH_MULT[31:0];
    unique case (state)
      H_M1:    mul_a = key_r[63:32];
      H_M2:    mul_b = HASH_MULT[63:32];
      default: ;
    endcase
    sh = {rem, acc[31]};
    if (sh >= SLOT_N) sh = sh - SLOT_N;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= H_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      H_IDLE: if (start) key_r <= key;
      H_M0: prod <= mul_a * mul_b;
      H_M1: begin
        acc  <= prod[63:32];
        prod <= mul_a * mul_b;
      end
      H_M2: begin
        acc  <= acc + prod[31:0];
        prod <= mul_a * mul_b;
      end
      H_SUM: begin
        acc <= acc + prod[31:0];
        rem <= '0;
        cnt <= '0;
      end
      H_MOD: begin
        rem <= sh[SW-1:0];
        acc <= {acc[30:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end
endmodule

// ===== src/limit_order_book_update.sv =====
// Top level of the limit order book update block: command sequencer over order and level memories.
// One item at a time. An item spends time on the slot hash (longer when ORDER_SLOTS is not a
// power of two), on each order-table slot probed, on each slot passed while closing the gap
// after a removal (longer when ORDER_SLOTS is not a power of two), on each level read or
// written, on each level walked when the best price is rescanned and on reading the result level.
// All of it is bound by the single read port of each memory and the shared hash multiplier.
// After reset the order table is cleared slot by slot; after reset and after each
// window base write the level table is cleared level by level. No item is taken meanwhile.
module limit_order_book_update import lobu_pkg::*; #(
  parameter int ORDER_SLOTS  = 4096,
  parameter int PRICE_LEVELS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        cmd,
  input  logic [63:0]       order_ref,
  input  logic [63:0]       new_ref,
  input  logic              side,
  input  logic [31:0]       price,
  input  logic [31:0]       shares,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [31:0]       high_bid,
  output logic [31:0]       low_ask,
  output logic [31:0]       bid_level_shares,
  output logic [31:0]       ask_level_shares
);
  localparam int SW = $clog2(ORDER_SLOTS);
  localparam int LW = $clog2(PRICE_LEVELS);
  localparam logic [SW:0]   SLOT_N    = (SW+1)'(ORDER_SLOTS);
  localparam logic [SW-1:0] SLOT_LAST = SW'(ORDER_SLOTS - 1);
  localparam logic [31:0]   LEVEL_N   = 32'(PRICE_LEVELS);

  st_t state, state_next;

  logic [2:0]  cmd_r;
  logic [63:0] ref_r, nref_r;
  logic        side_r;
  logic [31:0] price_r, shares_r;
  logic [1:0]  status_r;
  logic [31:0] win_base, top_bid, top_ask;
  logic [SW:0] fill;
  logic [SW-1:0] p, hole;
  logic [SW:0] n;
  logic        os;
  logic [31:0] op, qty;
  logic        drop, empty;
  slot_t       ent;

  logic          hash_start, hash_done;
  logic [63:0]   hash_key;
  logic [SW-1:0] hash_home;

  slot_t       s_rd, s_wdata;
  logic        s_we, s_busy;
  logic [SW-1:0] s_waddr;
  level_t      l_rd, l_wdata;
  logic        l_we, l_busy, cfg_wr;
  logic [LW-1:0] l_addr;

  logic        accept, in_win_in, in_win_lv, go_hash, key_hit, is_exec, move, ins_side;
  logic [31:0] lv_price, lv_off, in_off, newsh;
  logic [63:0] ins_key;
  logic [SW-1:0] next_p;
  logic [SW:0] d_p, d_hole;
  level_t      lv_take, lv_give;
  logic [12:0] take_cnt, scan_cnt;
  slot_t       new_ent;

  lobu_hash #(.SLOTS(ORDER_SLOTS)) u_hash (
    .clk(clk), .rst(rst), .start(hash_start), .key(hash_key),
    .done(hash_done), .home(hash_home)
  );

  lobu_ram #(.DEPTH(ORDER_SLOTS), .WIDTH($bits(slot_t))) u_slots (
    .clk(clk), .rst(rst), .clr(1'b0), .raddr(p), .rdata(s_rd),
    .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .busy(s_busy)
  );

  lobu_ram #(.DEPTH(PRICE_LEVELS), .WIDTH($bits(level_t))) u_levels (
    .clk(clk), .rst(rst), .clr(cfg_wr), .raddr(l_addr), .rdata(l_rd),
    .we(l_we), .waddr(l_addr), .wdata(l_wdata), .busy(l_busy)
  );

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_BASE_PRICE);
  assign prdata   = (paddr[2] == REG_BASE_PRICE) ? win_base : '0;
  assign in_ready = (state == S_IDLE) && !s_busy && !l_busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    in_off    = price - win_base;
    in_win_in = in_off < LEVEL_N;
    go_hash   = (cmd >= CMD_EXECUTE && cmd <= CMD_REPLACE) ||
                (cmd == CMD_ADD && in_win_in && fill != SLOT_N);

    case (state)
      S_TAKE_RD, S_TAKE_WR:       lv_price = op;
      S_SC_START, S_SC_RD, S_SC_CK: lv_price = os ? top_ask : top_bid;
      default:                    lv_price = price_r;
    endcase
    lv_off    = lv_price - win_base;
    in_win_lv = lv_off < LEVEL_N;
    l_addr    = lv_off[LW-1:0];

    next_p  = (p == SLOT_LAST) ? '0 : p + 1'b1;
    key_hit = s_rd.used && (s_rd.key == ref_r);
    is_exec = (cmd_r == CMD_EXECUTE) || (cmd_r == CMD_CANCEL);
    newsh   = s_rd.shares - shares_r;

    d_p    = {1'b0, p} - {1'b0, hash_home} + ((p < hash_home) ? SLOT_N : '0);
    d_hole = {1'b0, hole} - {1'b0, hash_home} + ((hole < hash_home) ? SLOT_N : '0);
    move   = d_p > d_hole;

    ins_side = (cmd_r == CMD_ADD) ? side_r : os;
    ins_key  = (cmd_r == CMD_ADD) ? ref_r : nref_r;
    new_ent  = '{used: 1'b1, side: ins_side, shares: shares_r, price: price_r, key: ins_key};

    lv_take = l_rd;
    if (!os) begin
      lv_take.bid_total = l_rd.bid_total - qty;
      if (drop) lv_take.bid_count = l_rd.bid_count - 13'd1;
    end else begin
      lv_take.ask_total = l_rd.ask_total - qty;
      if (drop) lv_take.ask_count = l_rd.ask_count - 13'd1;
    end
    take_cnt = os ? lv_take.ask_count : lv_take.bid_count;
    scan_cnt = os ? l_rd.ask_count : l_rd.bid_count;

    lv_give = l_rd;
    if (!ins_side) begin
      lv_give.bid_total = l_rd.bid_total + shares_r;
      lv_give.bid_count = l_rd.bid_count + 13'd1;
    end else begin
      lv_give.ask_total = l_rd.ask_total + shares_r;
      lv_give.ask_count = l_rd.ask_count + 13'd1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = go_hash ? ((cmd == CMD_ADD) ? S_INS_HASH : S_FIND_HASH)
                                         : S_OUT_RD;
      end
      S_FIND_HASH: if (hash_done) state_next = S_FIND_RD;
      S_FIND_RD:   state_next = (n == SLOT_N) ? S_OUT_RD : S_FIND_CK;
      S_FIND_CK: begin
        if (!s_rd.used)   state_next = S_OUT_RD;
        else if (key_hit) state_next = S_TAKE_RD;
        else              state_next = S_FIND_RD;
      end
      S_TAKE_RD: begin
        if (in_win_lv) state_next = S_TAKE_WR;
        else           state_next = drop ? S_ER_START : S_OUT_RD;
      end
      S_TAKE_WR:  state_next = drop ? S_ER_START : S_OUT_RD;
      S_ER_START: state_next = S_ER_RD;
      S_ER_RD:    state_next = (n == SLOT_N) ? S_ER_END : S_ER_CK;
      S_ER_CK:    state_next = (!s_rd.used || p == hole) ? S_ER_END : S_ER_HASH;
      S_ER_HASH:  if (hash_done) state_next = S_ER_RD;
      S_ER_END: begin
        if (cmd_r == CMD_REPLACE && in_win_lv && fill != SLOT_N) state_next = S_INS_HASH;
        else                                                    state_next = S_SC_START;
      end
      S_INS_HASH: if (hash_done) state_next = S_INS_RD;
      S_INS_RD:   state_next = S_INS_CK;
      S_INS_CK:   state_next = s_rd.used ? S_INS_RD : S_GIVE_RD;
      S_GIVE_RD:  state_next = S_GIVE_WR;
      S_GIVE_WR:  state_next = (cmd_r == CMD_ADD) ? S_OUT_RD : S_SC_START;
      S_SC_START: begin
        if (empty && ((!os && op == top_bid) || (os && op == top_ask))) state_next = S_SC_RD;
        else                                                           state_next = S_OUT_RD;
      end
      S_SC_RD:  state_next = in_win_lv ? S_SC_CK : S_OUT_RD;
      S_SC_CK:  state_next = (scan_cnt != 13'd0) ? S_OUT_RD : S_SC_RD;
      S_OUT_RD: state_next = S_OUT_WR;
      S_OUT_WR: if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    hash_start = 1'b0;
    hash_key   = nref_r;
    s_we       = 1'b0;
    s_waddr    = p;
    s_wdata    = s_rd;
    l_we       = 1'b0;
    l_wdata    = lv_take;
    unique case (state)
      S_IDLE: begin
        hash_start = accept && go_hash;
        hash_key   = order_ref;
      end
      S_FIND_CK: begin
        if (key_hit && is_exec && newsh != 32'd0) begin
          s_we           = 1'b1;
          s_wdata.shares = newsh;
        end
      end
      S_TAKE_WR: l_we = 1'b1;
      S_ER_CK: begin
        hash_start = s_rd.used && (p != hole);
        hash_key   = s_rd.key;
      end
      S_ER_HASH: begin
        if (hash_done && move) begin
          s_we    = 1'b1;
          s_waddr = hole;
          s_wdata = ent;
        end
      end
      S_ER_END: begin
        s_we       = 1'b1;
        s_waddr    = hole;
        s_wdata    = '0;
        hash_start = (cmd_r == CMD_REPLACE) && in_win_lv && (fill != SLOT_N);
      end
      S_INS_CK: begin
        if (!s_rd.used) begin
          s_we    = 1'b1;
          s_wdata = new_ent;
        end
      end
      S_GIVE_WR: begin
        l_we    = 1'b1;
        l_wdata = lv_give;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_base   <= '0;
      top_bid    <= '0;
      top_ask    <= '1;
      fill       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT_WR) out_valid <= 1'b0;
      if (cfg_wr) begin
        win_base   <= pwdata;
        top_bid    <= '0;
        top_ask    <= '1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r    <= cmd;
            ref_r    <= order_ref;
            nref_r   <= new_ref;
            side_r   <= side;
            price_r  <= price;
            shares_r <= shares;
            empty    <= 1'b0;
            status_r <= (cmd == CMD_ADD && !go_hash) ? STAT_IGNORED : STAT_OK;
          end
        end
        S_FIND_HASH: begin
          if (hash_done) begin
            p <= hash_home;
            n <= '0;
          end
        end
        S_FIND_RD: if (n == SLOT_N) status_r <= STAT_UNKNOWN;
        S_FIND_CK: begin
          if (!s_rd.used) begin
            status_r <= STAT_UNKNOWN;
          end else if (key_hit) begin
            os   <= s_rd.side;
            op   <= s_rd.price;
            qty  <= is_exec ? shares_r : s_rd.shares;
            drop <= is_exec ? (newsh == 32'd0) : 1'b1;
          end else begin
            p <= next_p;
            n <= n + 1'b1;
          end
        end
        S_TAKE_WR: empty <= drop && (take_cnt == 13'd0);
        S_ER_START: begin
          hole <= p;
          p    <= next_p;
          n    <= '0;
          fill <= fill - 1'b1;
        end
        S_ER_CK: ent <= s_rd;
        S_ER_HASH: begin
          if (hash_done) begin
            if (move) hole <= p;
            p <= next_p;
            n <= n + 1'b1;
          end
        end
        S_ER_END: if (cmd_r == CMD_REPLACE && !in_win_lv) status_r <= STAT_IGNORED;
        S_INS_HASH: if (hash_done) p <= hash_home;
        S_INS_CK: begin
          if (s_rd.used) p <= next_p;
          else           fill <= fill + 1'b1;
        end
        S_GIVE_WR: begin
          if (!ins_side && price_r > top_bid) top_bid <= price_r;
          if (ins_side && price_r < top_ask)  top_ask <= price_r;
        end
        S_SC_CK: begin
          if (scan_cnt == 13'd0) begin
            if (os) top_ask <= top_ask + 32'd1;
            else    top_bid <= top_bid - 32'd1;
          end
        end
        S_OUT_WR: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            status           <= status_r;
            high_bid         <= top_bid;
            low_ask          <= top_ask;
            bid_level_shares <= in_win_lv ? l_rd.bid_total : '0;
            ask_level_shares <= in_win_lv ? l_rd.ask_total : '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
